>>> design/emvr_pkg.sv
// shared types, constants and tables for the euler-angle vector rotator
// used by emvr_coef, emvr_lane, the top level and the checker
package emvr_pkg;

  // coordinate and coefficient formats
  localparam int COORD_BITS    = 24;
  localparam int COEF_FRAC_DEF = 17;
  localparam int ANGLE_BITS    = 15;

  // cordic datapath
  localparam int CORDIC_STEPS = 20;
  localparam int XW           = 34;  // q30 x and y with headroom
  localparam int ZW           = 26;  // angle in 2^-16 degree
  localparam logic signed [XW-1:0] CORDIC_GAIN = 34'sd652032874;

  // angle units of 1/64 degree
  localparam logic signed [ANGLE_BITS:0] FULL_TURN    = 16'sd23040;
  localparam logic signed [ANGLE_BITS:0] HALF_TURN    = 16'sd11520;
  localparam logic signed [ANGLE_BITS:0] QUARTER_TURN = 16'sd5760;

  // register indexes
  localparam logic [1:0] REG_ANGLE_ONE   = 2'd0;
  localparam logic [1:0] REG_ANGLE_TWO   = 2'd1;
  localparam logic [1:0] REG_ANGLE_THREE = 2'd2;

  // input and result words
  typedef struct packed {
    logic signed [COORD_BITS-1:0] pos_x;
    logic signed [COORD_BITS-1:0] pos_y;
    logic signed [COORD_BITS-1:0] pos_z;
  } in_word_t;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] rot_x;
    logic signed [COORD_BITS-1:0] rot_y;
    logic signed [COORD_BITS-1:0] rot_z;
    logic                         clipped;
  } out_word_t;

  // coefficient sequencer
  typedef enum logic [2:0] {
    CS_LOAD,
    CS_ITER,
    CS_STORE,
    CS_MUL,
    CS_MAT,
    CS_READY
  } coef_state_e;

  // arctangent of 2^-i in 2^-16 degree
  function automatic logic signed [ZW-1:0] atan_lut(input logic [4:0] idx);
    logic signed [ZW-1:0] v;
    case (idx)
      5'd0:  v = 26'sd2949120;
      5'd1:  v = 26'sd1740967;
      5'd2:  v = 26'sd919879;
      5'd3:  v = 26'sd466945;
      5'd4:  v = 26'sd234379;
      5'd5:  v = 26'sd117304;
      5'd6:  v = 26'sd58666;
      5'd7:  v = 26'sd29335;
      5'd8:  v = 26'sd14668;
      5'd9:  v = 26'sd7334;
      5'd10: v = 26'sd3667;
      5'd11: v = 26'sd1833;
      5'd12: v = 26'sd917;
      5'd13: v = 26'sd458;
      5'd14: v = 26'sd229;
      5'd15: v = 26'sd115;
      5'd16: v = 26'sd57;
      5'd17: v = 26'sd29;
      5'd18: v = 26'sd14;
      5'd19: v = 26'sd7;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

>>> design/emvr_coef.sv
// angle registers, shared iterative cordic and matrix builder
// depends on emvr_pkg
module emvr_coef import emvr_pkg::*; #(
  parameter int FracBits = COEF_FRAC_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [1:0]                         cfg_idx_i,
  input  logic [ANGLE_BITS-1:0]              cfg_data_i,
  output logic                               ready_o,
  output logic signed [FracBits+2:0]         m_o [9]
);

  localparam int CF = FracBits + 2;
  localparam int MW = FracBits + 3;
  localparam int PW = 2 * CF;
  localparam logic [4:0] LAST_ITER = 5'(CORDIC_STEPS - 1);
  localparam logic [3:0] LAST_STEP = 4'd13;
  localparam logic [1:0] LAST_ANG  = 2'd2;

  coef_state_e state_q, state_d;

  logic signed [ANGLE_BITS-1:0] ang_reg_q [3];
  logic [1:0] ang_q;
  logic [4:0] it_q;
  logic [3:0] step_q;

  logic signed [XW-1:0] x_q, y_q;
  logic signed [ZW-1:0] z_q;
  logic                 flip_q;

  logic signed [CF-1:0] cos_q [3];
  logic signed [CF-1:0] sin_q [3];
  logic signed [CF-1:0] prod_q [14];
  logic signed [MW-1:0] m_q [9];

  // round q30 to the coefficient format and clamp to unity
  function automatic logic signed [CF-1:0] rnd_q30(input logic signed [XW-1:0] v);
    logic signed [XW:0] t;
    logic signed [XW:0] one;
    one = (XW+1)'(1) <<< FracBits;
    t = ((XW+1)'(v) + ((XW+1)'(1) <<< (29 - FracBits))) >>> (30 - FracBits);
    if (t > one) begin
      t = one;
    end else if (t < -one) begin
      t = -one;
    end
    return t[CF-1:0];
  endfunction

  // rounded fixed-point product of two coefficients
  function automatic logic signed [CF-1:0] qmul(input logic signed [CF-1:0] a,
                                                 input logic signed [CF-1:0] b);
    logic signed [PW-1:0] p;
    p = (PW'(a) * PW'(b) + (PW'(1) <<< (FracBits - 1))) >>> FracBits;
    return p[CF-1:0];
  endfunction

  // angle registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ang_reg_q[0] <= '0;
      ang_reg_q[1] <= '0;
      ang_reg_q[2] <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_ANGLE_ONE:   ang_reg_q[0] <= cfg_data_i;
        REG_ANGLE_TWO:   ang_reg_q[1] <= cfg_data_i;
        REG_ANGLE_THREE: ang_reg_q[2] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // angle select, wrap to half turn and fold into the right half plane
  logic signed [ANGLE_BITS:0] a_sel, a_wrap, a_fold;
  logic                       flip_d;
  logic signed [ZW-1:0]       z_init;

  always_comb begin
    case (ang_q)
      2'd0:    a_sel = -(16'(ang_reg_q[0]));
      2'd1:    a_sel = -(16'(ang_reg_q[1]));
      default: a_sel = 16'(ang_reg_q[2]);
    endcase
    if (a_sel >= HALF_TURN) begin
      a_wrap = a_sel - FULL_TURN;
    end else if (a_sel < -HALF_TURN) begin
      a_wrap = a_sel + FULL_TURN;
    end else begin
      a_wrap = a_sel;
    end
    flip_d = 1'b1;
    if (a_wrap > QUARTER_TURN) begin
      a_fold = a_wrap - HALF_TURN;
    end else if (a_wrap < -QUARTER_TURN) begin
      a_fold = a_wrap + HALF_TURN;
    end else begin
      a_fold = a_wrap;
      flip_d = 1'b0;
    end
    z_init = ZW'(a_fold) <<< 10;
  end

  // one cordic micro-rotation
  logic signed [XW-1:0] x_n, y_n, xs, ys, xf, yf;
  logic signed [ZW-1:0] z_n, at;

  always_comb begin
    xs = x_q >>> it_q;
    ys = y_q >>> it_q;
    at = atan_lut(it_q);
    if (!z_q[ZW-1]) begin
      x_n = x_q - ys;
      y_n = y_q + xs;
      z_n = z_q - at;
    end else begin
      x_n = x_q + ys;
      y_n = y_q - xs;
      z_n = z_q + at;
    end
    xf = flip_q ? -x_q : x_q;
    yf = flip_q ? -y_q : y_q;
  end

  // operand select for the shared multiplier
  logic signed [CF-1:0] op_a, op_b;

  always_comb begin
    case (step_q)
      4'd0:    begin op_a = cos_q[0];   op_b = cos_q[2]; end
      4'd1:    begin op_a = sin_q[0];   op_b = sin_q[1]; end
      4'd2:    begin op_a = prod_q[1];  op_b = sin_q[2]; end
      4'd3:    begin op_a = cos_q[2];   op_b = sin_q[0]; end
      4'd4:    begin op_a = prod_q[3];  op_b = sin_q[1]; end
      4'd5:    begin op_a = cos_q[0];   op_b = sin_q[2]; end
      4'd6:    begin op_a = cos_q[1];   op_b = sin_q[0]; end
      4'd7:    begin op_a = cos_q[1];   op_b = sin_q[2]; end
      4'd8:    begin op_a = cos_q[1];   op_b = cos_q[2]; end
      4'd9:    begin op_a = cos_q[0];   op_b = sin_q[1]; end
      4'd10:   begin op_a = prod_q[9];  op_b = sin_q[2]; end
      4'd11:   begin op_a = prod_q[0];  op_b = sin_q[1]; end
      4'd12:   begin op_a = sin_q[0];   op_b = sin_q[2]; end
      4'd13:   begin op_a = cos_q[0];   op_b = cos_q[1]; end
      default: begin op_a = '0;         op_b = '0;       end
    endcase
  end

  // sequencer state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= CS_LOAD;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      CS_LOAD:  state_d = CS_ITER;
      CS_ITER:  if (it_q == LAST_ITER) state_d = CS_STORE;
      CS_STORE: state_d = (ang_q == LAST_ANG) ? CS_MUL : CS_LOAD;
      CS_MUL:   if (step_q == LAST_STEP) state_d = CS_MAT;
      CS_MAT:   state_d = CS_READY;
      CS_READY: state_d = CS_READY;
      default:  state_d = CS_LOAD;
    endcase
    if (cfg_we_i) begin
      state_d = CS_LOAD;
    end
    ready_o = (state_q == CS_READY);
  end

  // sequencer counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ang_q  <= '0;
      it_q   <= '0;
      step_q <= '0;
    end else if (cfg_we_i) begin
      ang_q <= '0;
    end else begin
      case (state_q)
        CS_LOAD:  it_q <= '0;
        CS_ITER:  it_q <= it_q + 5'd1;
        CS_STORE: begin
          step_q <= '0;
          if (ang_q != LAST_ANG) ang_q <= ang_q + 2'd1;
        end
        CS_MUL:   step_q <= step_q + 4'd1;
        default: ;
      endcase
    end
  end

  // cordic, coefficient and matrix datapath
  always_ff @(posedge clk_i) begin
    case (state_q)
      CS_LOAD: begin
        x_q    <= CORDIC_GAIN;
        y_q    <= '0;
        z_q    <= z_init;
        flip_q <= flip_d;
      end
      CS_ITER: begin
        x_q <= x_n;
        y_q <= y_n;
        z_q <= z_n;
      end
      CS_STORE: begin
        cos_q[ang_q] <= rnd_q30(xf);
        sin_q[ang_q] <= rnd_q30(yf);
      end
      CS_MUL:   prod_q[step_q] <= qmul(op_a, op_b);
      CS_MAT: begin
        m_q[0] <= MW'(prod_q[0]) + MW'(prod_q[2]);
        m_q[1] <= MW'(prod_q[4]) - MW'(prod_q[5]);
        m_q[2] <= MW'(prod_q[6]);
        m_q[3] <= MW'(prod_q[7]);
        m_q[4] <= MW'(prod_q[8]);
        m_q[5] <= -(MW'(sin_q[1]));
        m_q[6] <= MW'(prod_q[10]) - MW'(prod_q[3]);
        m_q[7] <= MW'(prod_q[11]) + MW'(prod_q[12]);
        m_q[8] <= MW'(prod_q[13]);
      end
      default: ;
    endcase
  end

  assign m_o = m_q;

endmodule

>>> design/emvr_lane.sv
// one matrix row: three products, rounded sum and saturation
// depends on emvr_pkg
module emvr_lane import emvr_pkg::*; #(
  parameter int FracBits = COEF_FRAC_DEF
) (
  input  logic                         clk_i,
  input  logic                         en_i,
  input  logic signed [FracBits+2:0]   m_i [3],
  input  logic signed [COORD_BITS-1:0] p_i [3],
  output logic signed [COORD_BITS-1:0] res_o,
  output logic                         clip_o
);

  localparam int MW  = FracBits + 3;
  localparam int PRW = MW + COORD_BITS;
  localparam int SW  = PRW + 2;

  logic signed [PRW-1:0]        prod_q [3];
  logic signed [SW-1:0]         sum, rnd, hi, lo;
  logic signed [COORD_BITS-1:0] res_d, res_q;
  logic                         clip_d, clip_q;

  // product stage
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int j = 0; j < 3; j++) begin
        prod_q[j] <= PRW'(m_i[j]) * PRW'(p_i[j]);
      end
    end
  end

  // sum, round half up and saturate
  always_comb begin
    hi     = (SW'(1) <<< (COORD_BITS - 1)) - SW'(1);
    lo     = -hi - SW'(1);
    sum    = SW'(prod_q[0]) + SW'(prod_q[1]) + SW'(prod_q[2]);
    rnd    = (sum + (SW'(1) <<< (FracBits - 1))) >>> FracBits;
    clip_d = 1'b0;
    res_d  = rnd[COORD_BITS-1:0];
    if (rnd > hi) begin
      res_d  = hi[COORD_BITS-1:0];
      clip_d = 1'b1;
    end else if (rnd < lo) begin
      res_d  = lo[COORD_BITS-1:0];
      clip_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      res_q  <= res_d;
      clip_q <= clip_d;
    end
  end

  assign res_o  = res_q;
  assign clip_o = clip_q;

endmodule

>>> design/euler_angle_vector_rotation_top.sv
// an accepted word passes the lane product register, the lane result register and the output register
// throughput: one word per cycle while in_stall_o is low, three row lanes each with three multipliers
// after reset and after every register write the coefficient unit rebuilds the matrix
// (three cordic passes, then the shared multiplier steps); in_stall_o stays high meanwhile
// reset is asynchronous, active low, and clears the angles to zero and the pipeline
// depends on emvr_pkg, emvr_coef and emvr_lane
module euler_angle_vector_rotation_top import emvr_pkg::*; #(
  parameter int COEF_FRAC_BITS = COEF_FRAC_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [1:0]            cfg_idx_i,
  input  logic [ANGLE_BITS-1:0] cfg_data_i,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  in_word_t              in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output out_word_t             out_data_o
);

  localparam int MW = COEF_FRAC_BITS + 3;

  logic                         coef_ready;
  logic signed [MW-1:0]         mat [9];
  logic signed [COORD_BITS-1:0] pos_vec [3];
  logic signed [COORD_BITS-1:0] lane_res [3];
  logic [2:0]                   lane_clip;
  logic                         adv, accept;
  logic                         va_q, vb_q, out_valid_q;
  out_word_t                    out_data_q;

  // coefficient unit
  emvr_coef #(
    .FracBits (COEF_FRAC_BITS)
  ) u_coef (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .ready_o    (coef_ready),
    .m_o        (mat)
  );

  // pipeline moves whenever the output register is free
  assign adv        = !out_valid_q || !out_stall_i;
  assign in_stall_o = !(adv && coef_ready);
  assign accept     = in_valid_i && !in_stall_o;

  assign pos_vec[0] = in_data_i.pos_x;
  assign pos_vec[1] = in_data_i.pos_y;
  assign pos_vec[2] = in_data_i.pos_z;

  // one lane per matrix row
  for (genvar r = 0; r < 3; r++) begin : g_lane
    logic signed [MW-1:0] row [3];
    for (genvar j = 0; j < 3; j++) begin : g_col
      assign row[j] = mat[3*r+j];
    end
    emvr_lane #(
      .FracBits (COEF_FRAC_BITS)
    ) u_lane (
      .clk_i  (clk_i),
      .en_i   (adv),
      .m_i    (row),
      .p_i    (pos_vec),
      .res_o  (lane_res[r]),
      .clip_o (lane_clip[r])
    );
  end

  // stage valids
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q        <= 1'b0;
      vb_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      va_q        <= accept;
      vb_q        <= va_q;
      out_valid_q <= vb_q;
    end
  end

  // merge the lanes into the result word
  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_data_q.rot_x   <= lane_res[0];
      out_data_q.rot_y   <= lane_res[1];
      out_data_q.rot_z   <= lane_res[2];
      out_data_q.clipped <= |lane_clip;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

>>> design/emvr_chk.sv
// port-level checks for the rotator top level, attached by bind
// depends on emvr_pkg and euler_angle_vector_rotation_top
module emvr_chk import emvr_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      cfg_we_i,
  input logic      in_valid_i,
  input logic      in_stall_o,
  input logic      out_valid_o,
  input logic      out_stall_i,
  input out_word_t out_data_o
);

  localparam logic signed [COORD_BITS-1:0] ROT_MAX = {1'b0, {(COORD_BITS-1){1'b1}}};
  localparam logic signed [COORD_BITS-1:0] ROT_MIN = {1'b1, {(COORD_BITS-1){1'b0}}};

  // a held result word keeps its payload
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("result word changed while stalled");

  // coefficients are rebuilt after a register write
  a_cfg_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we_i |=> in_stall_o)
    else $error("word accepted right after a register write");

  // an accepted word reaches the output through the stage valids when not held
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) ##1 !out_stall_i ##1 !out_stall_i |=> out_valid_o)
    else $error("result word missing after pipeline latency");

  // a clipped word carries at least one saturated coordinate
  a_clip_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.clipped |->
      out_data_o.rot_x == ROT_MAX || out_data_o.rot_x == ROT_MIN ||
      out_data_o.rot_y == ROT_MAX || out_data_o.rot_y == ROT_MIN ||
      out_data_o.rot_z == ROT_MAX || out_data_o.rot_z == ROT_MIN)
    else $error("clip flag set without a saturated coordinate");

endmodule

bind euler_angle_vector_rotation_top emvr_chk u_emvr_chk (.*);

>>> tb/sv/euler_angle_vector_rotation_top_tb.sv
`timescale 1ns / 1ps
// self-checking bench for euler_angle_vector_rotation_top: random angles and vectors,
// random gaps on both sides, results checked against a bit-true rotation predictor
// depends on emvr_pkg and the design files
module euler_angle_vector_rotation_top_tb import emvr_pkg::*; ();

  localparam int FRAC = COEF_FRAC_DEF;
  localparam logic [1:0] REG_UNUSED = 2'd3;
  localparam int IDLE_LIMIT = 5000;
  localparam int PHASE_WORDS = 150;
  localparam int RANDOM_PHASES = 12;

  // predictor and store of expected rotated words
  class rot_scoreboard;
    int angle[3];
    out_word_t rot_q[$];
    int errors, checked, clip_seen;
    longint atan_q16[20] = '{2949120, 1740967, 919879, 466945, 234379, 117304, 58666,
                             29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29,
                             14, 7};

    function void set_angle(logic [1:0] idx, logic [ANGLE_BITS-1:0] val);
      if (idx == REG_ANGLE_ONE) angle[0] = $signed(val);
      else if (idx == REG_ANGLE_TWO) angle[1] = $signed(val);
      else if (idx == REG_ANGLE_THREE) angle[2] = $signed(val);
    endfunction

    function longint clamp_coef(longint v);
      longint r;
      longint one;
      one = 64'sd1 <<< FRAC;
      r = (v + (64'sd1 <<< (29 - FRAC))) >>> (30 - FRAC);
      if (r > one) r = one;
      if (r < -one) r = -one;
      return r;
    endfunction

    // cordic in rotation mode, angle in 1/64 degree
    function void sin_cos(int a, output longint c, output longint s);
      int r;
      bit flip;
      longint x, y, z, nx;
      r = ((a % 23040) + 23040) % 23040;
      flip = 0;
      if (r >= 11520) r -= 23040;
      if (r > 5760) begin
        r -= 11520;
        flip = 1;
      end else if (r < -5760) begin
        r += 11520;
        flip = 1;
      end
      x = 64'sd652032874;
      y = 0;
      z = longint'(r) * 1024;
      for (int i = 0; i < 20; i++) begin
        if (z >= 0) begin
          nx = x - (y >>> i);
          y = y + (x >>> i);
          z -= atan_q16[i];
        end else begin
          nx = x + (y >>> i);
          y = y - (x >>> i);
          z += atan_q16[i];
        end
        x = nx;
      end
      if (flip) begin
        x = -x;
        y = -y;
      end
      c = clamp_coef(x);
      s = clamp_coef(y);
    endfunction

    function longint qmul(longint a, longint b);
      return (a * b + (64'sd1 <<< (FRAC - 1))) >>> FRAC;
    endfunction

    function void note_input(in_word_t w);
      longint c1, s1, c2, s2, c3, s3;
      longint m[3][3];
      longint p[3];
      longint acc, r, hi, lo;
      logic signed [COORD_BITS-1:0] res[3];
      out_word_t e;
      hi = (64'sd1 <<< (COORD_BITS - 1)) - 1;
      lo = -hi - 1;
      sin_cos(-angle[0], c1, s1);
      sin_cos(-angle[1], c2, s2);
      sin_cos(angle[2], c3, s3);
      m[0][0] = qmul(c1, c3) + qmul(qmul(s1, s2), s3);
      m[0][1] = qmul(qmul(c3, s1), s2) - qmul(c1, s3);
      m[0][2] = qmul(c2, s1);
      m[1][0] = qmul(c2, s3);
      m[1][1] = qmul(c2, c3);
      m[1][2] = -s2;
      m[2][0] = qmul(qmul(c1, s2), s3) - qmul(c3, s1);
      m[2][1] = qmul(qmul(c1, c3), s2) + qmul(s1, s3);
      m[2][2] = qmul(c1, c2);
      p[0] = longint'(w.pos_x);
      p[1] = longint'(w.pos_y);
      p[2] = longint'(w.pos_z);
      e.clipped = 1'b0;
      for (int i = 0; i < 3; i++) begin
        acc = 0;
        for (int j = 0; j < 3; j++) acc += m[i][j] * p[j];
        r = (acc + (64'sd1 <<< (FRAC - 1))) >>> FRAC;
        if (r > hi) begin
          r = hi;
          e.clipped = 1'b1;
        end
        if (r < lo) begin
          r = lo;
          e.clipped = 1'b1;
        end
        res[i] = r[COORD_BITS-1:0];
      end
      e.rot_x = res[0];
      e.rot_y = res[1];
      e.rot_z = res[2];
      rot_q.push_back(e);
    endfunction

    function void check_result(out_word_t got);
      out_word_t e;
      if (rot_q.size() == 0) begin
        $display("%0t: unexpected result word %h", $time, got);
        errors++;
        return;
      end
      e = rot_q.pop_front();
      checked++;
      if (e.clipped) clip_seen++;
      if (got.rot_x !== e.rot_x) begin
        $display("%0t: rot_x expected %0d actual %0d", $time, e.rot_x, got.rot_x);
        errors++;
      end
      if (got.rot_y !== e.rot_y) begin
        $display("%0t: rot_y expected %0d actual %0d", $time, e.rot_y, got.rot_y);
        errors++;
      end
      if (got.rot_z !== e.rot_z) begin
        $display("%0t: rot_z expected %0d actual %0d", $time, e.rot_z, got.rot_z);
        errors++;
      end
      if (got.clipped !== e.clipped) begin
        $display("%0t: clipped expected %0b actual %0b", $time, e.clipped, got.clipped);
        errors++;
      end
    endfunction

    function int pending();
      return rot_q.size();
    endfunction
  endclass

  logic clk_i, rst_ni;
  logic cfg_we_i;
  logic [1:0] cfg_idx_i;
  logic [ANGLE_BITS-1:0] cfg_data_i;
  logic in_valid_i, in_stall_o;
  in_word_t in_data_i;
  logic out_valid_o, out_stall_i;
  out_word_t out_data_o;

  rot_scoreboard sb;
  int idle_cycles, words_sent, cfg_writes, stall_hold;
  bit out_stalling, in_gapping;

  euler_angle_vector_rotation_top uut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .in_valid_i, .in_stall_o, .in_data_i,
    .out_valid_o, .out_stall_i, .out_data_o
  );

  // clock
  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  // handshake monitors and watchdog
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && !in_stall_o) sb.note_input(in_data_i);
    if (rst_ni && out_valid_o && !out_stall_i) sb.check_result(out_data_o);
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("%0t: watchdog expired, %0d words outstanding", $time, sb.pending());
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  // receiver stalls: random, occasional long holds, none when disabled
  always @(negedge clk_i) begin
    if (stall_hold > 0) begin
      stall_hold <= stall_hold - 1;
      out_stall_i <= 1'b1;
    end else if (out_stalling && $urandom_range(0, 99) < 3) begin
      stall_hold <= $urandom_range(5, 30);
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= out_stalling && ($urandom_range(0, 3) == 0);
    end
  end

  function automatic int gap_len();
    int p;
    p = $urandom_range(0, 99);
    if (!in_gapping || p < 60) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // entered and left at a falling edge; valid stays high for a following word
  task automatic send_word(in_word_t w);
    int g;
    g = gap_len();
    if (g > 0) begin
      in_valid_i <= 1'b0;
      repeat (g) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= w;
    do @(posedge clk_i); while (in_stall_o);
    @(negedge clk_i);
    words_sent++;
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(negedge clk_i);
    repeat (6) @(negedge clk_i);
  endtask

  task automatic write_angle(logic [1:0] idx, logic [ANGLE_BITS-1:0] val);
    drain();
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    sb.set_angle(idx, val);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    cfg_writes++;
  endtask

  task automatic set_angles(int a1, int a2, int a3);
    write_angle(REG_ANGLE_ONE, a1[ANGLE_BITS-1:0]);
    write_angle(REG_ANGLE_TWO, a2[ANGLE_BITS-1:0]);
    write_angle(REG_ANGLE_THREE, a3[ANGLE_BITS-1:0]);
  endtask

  function automatic int rand_angle();
    if ($urandom_range(0, 9) == 0) return $signed(15'($urandom()));
    return int'($urandom_range(0, 23040)) - 11520;
  endfunction

  function automatic logic [COORD_BITS-1:0] rand_coord();
    int p;
    p = $urandom_range(0, 9);
    if (p == 0) return $urandom_range(0, 1) ? 24'h7fffff : 24'h800000;
    if (p < 3) return 24'($signed(int'($urandom_range(0, 8191)) - 4096));
    return 24'($urandom());
  endfunction

  function automatic in_word_t vec(int x, int y, int z);
    in_word_t w;
    w.pos_x = x[COORD_BITS-1:0];
    w.pos_y = y[COORD_BITS-1:0];
    w.pos_z = z[COORD_BITS-1:0];
    return w;
  endfunction

  task automatic directed_vectors();
    int mx, mn;
    mx = 8388607;
    mn = -8388608;
    send_word(vec(0, 0, 0));
    send_word(vec(mx, mx, mx));
    send_word(vec(mn, mn, mn));
    send_word(vec(mx, mn, mx));
    send_word(vec(256, 0, 0));
    send_word(vec(0, -256, 0));
    send_word(vec(0, 0, 1));
  endtask

  initial begin
    in_word_t w;
    sb = new();
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = REG_ANGLE_ONE;
    cfg_data_i = '0;
    in_valid_i = 1'b0;
    in_data_i = '0;
    out_stall_i = 1'b0;
    stall_hold = 0;
    idle_cycles = 0;
    out_stalling = 0;
    in_gapping = 0;
    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed: reset angles, extremes, quarter turns, wrap beyond a half turn
    directed_vectors();
    set_angles(11520, -11520, 5760);
    directed_vectors();
    set_angles(16383, -16384, -5760);
    directed_vectors();
    // unused register index must leave the angles alone
    write_angle(REG_UNUSED, 15'h1234);
    set_angles(5761, -5759, 2880);
    directed_vectors();

    // random phases, with and without idling on either side
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      out_stalling = (ph % 3 != 0);
      in_gapping = (ph % 4 != 1);
      if (ph == RANDOM_PHASES - 1) set_angles(-11520, 11520, -11520);
      else set_angles(rand_angle(), rand_angle(), rand_angle());
      for (int k = 0; k < PHASE_WORDS; k++) begin
        w.pos_x = rand_coord();
        w.pos_y = rand_coord();
        w.pos_z = rand_coord();
        send_word(w);
        // hold the sender until the pipeline has emptied
        if (k == PHASE_WORDS / 2 && ph == 2) begin
          in_valid_i <= 1'b0;
          while (sb.pending() != 0) @(negedge clk_i);
        end
      end
    end

    drain();
    repeat (10) @(negedge clk_i);
    $display("covered %0d words over %0d register writes, %0d results checked",
             words_sent, cfg_writes, sb.checked);
    $display("%0d results saturated, %0d mismatches", sb.clip_seen, sb.errors);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

>>> filelist.f
design/emvr_pkg.sv
design/emvr_coef.sv
design/emvr_lane.sv
design/euler_angle_vector_rotation_top.sv
design/emvr_chk.sv
tb/sv/euler_angle_vector_rotation_top_tb.sv
